FILE: src/mwsm_pkg.sv
// Shared constants, types and state codes of the mecanum wheel speed mixer.
`default_nettype none

package mwsm_pkg;

   // Field widths
   localparam int CMD_W      = 16;
   localparam int GEOM_W     = 16;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 15;
   localparam int WHEEL_W    = 16;
   localparam int WHEELS     = 4;
   localparam int REQ_DATA_W = 3 * CMD_W;
   localparam int RSP_DATA_W = WHEELS * WHEEL_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Fixed-point layout of the wheel linear speed
   localparam int FRAC_BITS = 20;
   localparam int ROT_W     = 32;
   localparam int XY_W      = CMD_W + 1;
   localparam int V_W       = XY_W + FRAC_BITS + 2;
   localparam int VSAT_W    = 36;

   // Serial multiplier: 36-bit unsigned multiplicand, 16-bit multiplier
   localparam int MUL_A_W   = VSAT_W;
   localparam int MUL_B_W   = 16;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);
   localparam int GAIN_SHIFT = FRAC_BITS + 8;
   localparam int PMAG_W    = PROD_W - GAIN_SHIFT;

   // Rescale divider: quotient never exceeds the limit
   localparam int QUO_W     = LIMIT_W;
   localparam int DIV_CNT_W = $clog2(QUO_W);

   // Register reset values
   localparam logic [GEOM_W-1:0]  GEOM_RESET  = 16'd0;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd256;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd8000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GEOMETRY_SUM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_GAIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT  = 2'd2;

   // Wheel indexes
   localparam logic [1:0] WHEEL_1 = 2'd0;
   localparam logic [1:0] WHEEL_2 = 2'd1;
   localparam logic [1:0] WHEEL_3 = 2'd2;
   localparam logic [1:0] WHEEL_4 = 2'd3;

   // Saturation magnitudes of a 16-bit wheel speed
   localparam logic [WHEEL_W-1:0] SAT_MAG_NEG = 16'h8000;
   localparam logic [WHEEL_W-1:0] SAT_MAG_POS = 16'h7FFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROT_GO,
      ST_ROT_WAIT,
      ST_MOT_GO,
      ST_MOT_WAIT,
      ST_CHECK,
      ST_SCL_GO,
      ST_SCL_WAIT,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] mcand;
      logic [MUL_B_W-1:0] mplier;
   } mul_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

endpackage

`default_nettype wire

FILE: src/mwsm_serial_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module mwsm_serial_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mwsm_pkg::mul_req_type mul_req,
   output mwsm_pkg::mul_rsp_type      mul_rsp
);
   import mwsm_pkg::*;

   localparam logic [MUL_CNT_W-1:0] CNT_LAST = MUL_CNT_W'(MUL_B_W - 1);

   logic [MUL_A_W-1:0]   mcand_ff, mcand_in;
   logic [MUL_A_W-1:0]   hi_ff, hi_in;
   logic [MUL_B_W-1:0]   lo_ff, lo_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_A_W:0]     sum;

   // Partial product add: the low word holds the remaining multiplier bits
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);

   // Step control
   always_comb begin
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (mul_req.start) begin
         mcand_in = mul_req.mcand;
         hi_in    = '0;
         lo_in    = mul_req.mplier;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in   = sum[MUL_A_W:1];
         lo_in   = {sum[0], lo_ff[MUL_B_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         busy_in = (cnt_ff != CNT_LAST);
         done_in = (cnt_ff == CNT_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      cnt_ff   <= cnt_in;
   end

   assign mul_rsp.busy    = busy_ff;
   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = {hi_ff, lo_ff};

endmodule

`default_nettype wire

FILE: src/mecanum_wheel_speed_mixer_unit.sv
// Mecanum wheel speed mixer: body velocity command in, four motor speeds out.
//
// The req channel takes one word per body velocity command (forward speed,
// sideways speed, spin rate). The rsp channel gives at most one word per
// command: four signed motor speeds in tdata, and a stop flag in tuser. An
// all-zero command gives one stop word with zero speeds, and further
// all-zero commands give nothing until a nonzero command arrives.
// The csr channel writes geometry sum, motor gain and speed limit; it is
// always ready and should only be used while the block is idle.
// One command is worked at a time. For a nonzero command the serial
// multiplier runs once for the spin term and once per wheel. When the
// largest motor speed exceeds the limit, each wheel adds a multiply and a
// 15-step serial divide. The next command is taken in the cycle after the
// result word is loaded. A result word sits in the output register
// until taken; a new command is accepted meanwhile, and its result waits
// if the previous word has still not been taken. Reset clears the stop
// history, empties the output register and loads the register defaults.
`default_nettype none

module mecanum_wheel_speed_mixer_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // req_tdata: speed_x [15:0], speed_y [31:16], spin_rate [47:32]
   input  wire logic [mwsm_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // rsp_tdata: wheel_speed_1 [15:0], wheel_speed_2 [31:16],
   //            wheel_speed_3 [47:32], wheel_speed_4 [63:48]
   output logic [mwsm_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // rsp_tuser: stop_command [0]
   output logic                                    rsp_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mwsm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mwsm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mwsm_pkg::*;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

   state_type state_ff, state_in;

   // Configuration and command state
   logic [GEOM_W-1:0]         geom_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic [LIMIT_W-1:0]        limit_ff;
   logic                      stop_sent_ff;
   logic                      stop_pend_ff;
   logic signed [CMD_W-1:0]   x_ff, y_ff, r_ff;
   logic signed [ROT_W-1:0]   rot_ff;
   logic                      neg_ff;
   logic [1:0]                idx_ff;
   logic signed [WHEEL_W-1:0] m_ff [WHEELS];
   logic [WHEEL_W-1:0]        mx_ff;
   logic [WHEEL_W-1:0]        rem_ff;
   logic [QUO_W-1:0]          quo_ff;
   logic [DIV_CNT_W-1:0]      div_cnt_ff;

   // Output register
   logic                      rsp_valid_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic                      rsp_stop_ff;

   // Decode from the state machine
   logic        accept;
   logic        cmd_zero;
   logic        emit_load;
   logic        div_last;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   // Datapath nets
   logic                      add_y, add_rot, neg_motor;
   logic signed [XY_W-1:0]    xy;
   logic signed [V_W-1:0]     v_lin, rot_ext, v;
   logic                      v_fits;
   logic [VSAT_W-1:0]         v_low;
   logic [VSAT_W-1:0]         v_mag;
   logic [CMD_W-1:0]          r_mag;
   logic [PMAG_W-1:0]         p_mag;
   logic [WHEEL_W-1:0]        sat_mag;
   logic signed [WHEEL_W-1:0] m_new;
   logic signed [WHEEL_W-1:0] m_sel;
   logic [WHEEL_W-1:0]        m_mag;
   logic [WHEEL_W:0]          trial;
   logic [WHEEL_W+1:0]        diff;
   logic                      q_bit;
   logic [QUO_W-1:0]          quo_next;
   logic [WHEEL_W-1:0]        quo_ext;
   logic signed [WHEEL_W-1:0] m_scaled;

   mwsm_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign cmd_zero  = (req_tdata == '0);
   assign csr_ready = 1'b1;

   // Wheel mix: x -/+ y +/- r*G per wheel, saturated to a 16-bit integer part
   assign add_y     = (idx_ff == WHEEL_2) || (idx_ff == WHEEL_3);
   assign add_rot   = (idx_ff == WHEEL_1) || (idx_ff == WHEEL_3);
   assign neg_motor = (idx_ff == WHEEL_1) || (idx_ff == WHEEL_3);
   assign xy        = add_y ? ({x_ff[CMD_W-1], x_ff} + {y_ff[CMD_W-1], y_ff})
                            : ({x_ff[CMD_W-1], x_ff} - {y_ff[CMD_W-1], y_ff});
   assign v_lin     = {{(V_W-XY_W-FRAC_BITS){xy[XY_W-1]}}, xy, {FRAC_BITS{1'b0}}};
   assign rot_ext   = {{(V_W-ROT_W){rot_ff[ROT_W-1]}}, rot_ff};
   assign v         = add_rot ? (v_lin + rot_ext) : (v_lin - rot_ext);
   assign v_fits    = (v[V_W-1:VSAT_W-1] == '0) || (v[V_W-1:VSAT_W-1] == '1);
   assign v_low     = v[VSAT_W-1:0];

   always_comb begin
      if (!v_fits) begin
         v_mag = v[V_W-1] ? {1'b1, {(VSAT_W-1){1'b0}}} : {1'b0, {(VSAT_W-1){1'b1}}};
      end else if (v_low[VSAT_W-1]) begin
         v_mag = '0 - v_low;
      end else begin
         v_mag = v_low;
      end
   end

   assign r_mag = r_ff[CMD_W-1] ? (CMD_W'(0) - r_ff) : r_ff;

   // Motor speed: magnitude of v*gain/2^28 truncated, signed, saturated
   assign p_mag = mul_rsp.product[PROD_W-1:GAIN_SHIFT];

   always_comb begin
      if (neg_ff) begin
         sat_mag = (p_mag > PMAG_W'(SAT_MAG_NEG)) ? SAT_MAG_NEG : p_mag[WHEEL_W-1:0];
      end else begin
         sat_mag = (p_mag > PMAG_W'(SAT_MAG_POS)) ? SAT_MAG_POS : p_mag[WHEEL_W-1:0];
      end
   end

   assign m_new = neg_ff ? (WHEEL_W'(0) - sat_mag) : sat_mag;

   // Rescale: |m|*limit, then one restoring divide step per cycle by the max
   assign m_sel    = m_ff[idx_ff];
   assign m_mag    = m_sel[WHEEL_W-1] ? (WHEEL_W'(0) - m_sel) : m_sel;
   assign trial    = {rem_ff, quo_ff[QUO_W-1]};
   assign diff     = {1'b0, trial} - {2'b00, mx_ff};
   assign q_bit    = !diff[WHEEL_W+1];
   assign quo_next = {quo_ff[QUO_W-2:0], q_bit};
   assign quo_ext  = {{(WHEEL_W-QUO_W){1'b0}}, quo_next};
   assign m_scaled = neg_ff ? (WHEEL_W'(0) - quo_ext) : quo_ext;
   assign div_last = (div_cnt_ff == DIV_LAST);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!cmd_zero) begin
                  state_in = ST_ROT_GO;
               end else if (!stop_sent_ff) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_ROT_GO:   state_in = ST_ROT_WAIT;
         ST_ROT_WAIT: begin
            if (mul_rsp.done) state_in = ST_MOT_GO;
         end
         ST_MOT_GO:   state_in = ST_MOT_WAIT;
         ST_MOT_WAIT: begin
            if (mul_rsp.done) state_in = (idx_ff == WHEEL_4) ? ST_CHECK : ST_MOT_GO;
         end
         ST_CHECK: begin
            state_in = (mx_ff > {1'b0, limit_ff}) ? ST_SCL_GO : ST_EMIT;
         end
         ST_SCL_GO:   state_in = ST_SCL_WAIT;
         ST_SCL_WAIT: begin
            if (mul_rsp.done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) state_in = (idx_ff == WHEEL_4) ? ST_EMIT : ST_SCL_GO;
         end
         ST_EMIT: begin
            if (emit_load) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // State machine outputs
   always_comb begin
      req_tready     = 1'b0;
      emit_load      = 1'b0;
      mul_req.start  = 1'b0;
      mul_req.mcand  = {{(MUL_A_W-CMD_W){1'b0}}, r_mag};
      mul_req.mplier = geom_ff;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_ROT_GO: mul_req.start = 1'b1;
         ST_MOT_GO: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = v_mag;
            mul_req.mplier = gain_ff;
         end
         ST_SCL_GO: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = {{(MUL_A_W-WHEEL_W){1'b0}}, m_mag};
            mul_req.mplier = {{(MUL_B_W-LIMIT_W){1'b0}}, limit_ff};
         end
         ST_EMIT:   emit_load = !rsp_valid_ff || rsp_tready;
         default:   req_tready = 1'b0;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         geom_ff      <= GEOM_RESET;
         gain_ff      <= GAIN_RESET;
         limit_ff     <= LIMIT_RESET;
         stop_sent_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GEOMETRY_SUM: geom_ff  <= csr_data[GEOM_W-1:0];
               CSR_MOTOR_GAIN:   gain_ff  <= csr_data[GAIN_W-1:0];
               CSR_SPEED_LIMIT:  limit_ff <= csr_data[LIMIT_W-1:0];
               default:          geom_ff  <= geom_ff;
            endcase
         end
         if (accept) begin
            stop_sent_ff <= cmd_zero;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff         <= req_tdata[CMD_W-1:0];
         y_ff         <= req_tdata[2*CMD_W-1:CMD_W];
         r_ff         <= req_tdata[3*CMD_W-1:2*CMD_W];
         stop_pend_ff <= cmd_zero;
         mx_ff        <= '0;
         idx_ff       <= WHEEL_1;
      end
      case (state_ff)
         ST_ROT_GO: neg_ff <= r_ff[CMD_W-1];
         ST_ROT_WAIT: begin
            if (mul_rsp.done) begin
               rot_ff <= neg_ff ? (ROT_W'(0) - mul_rsp.product[ROT_W-1:0])
                                : mul_rsp.product[ROT_W-1:0];
            end
         end
         ST_MOT_GO: neg_ff <= v[V_W-1] ^ neg_motor;
         ST_MOT_WAIT: begin
            if (mul_rsp.done) begin
               m_ff[idx_ff] <= m_new;
               if (sat_mag > mx_ff) mx_ff <= sat_mag;
               idx_ff <= idx_ff + 1'b1;
            end
         end
         ST_SCL_GO: neg_ff <= m_sel[WHEEL_W-1];
         ST_SCL_WAIT: begin
            if (mul_rsp.done) begin
               rem_ff     <= mul_rsp.product[WHEEL_W+QUO_W-1:QUO_W];
               quo_ff     <= mul_rsp.product[QUO_W-1:0];
               div_cnt_ff <= '0;
            end
         end
         ST_DIV: begin
            rem_ff     <= q_bit ? diff[WHEEL_W-1:0] : trial[WHEEL_W-1:0];
            quo_ff     <= quo_next;
            div_cnt_ff <= div_cnt_ff + 1'b1;
            if (div_last) begin
               m_ff[idx_ff] <= m_scaled;
               idx_ff       <= idx_ff + 1'b1;
            end
         end
         default: neg_ff <= neg_ff;
      endcase
      if (emit_load) begin
         rsp_stop_ff <= stop_pend_ff;
         rsp_data_ff <= stop_pend_ff ? '0 : {m_ff[3], m_ff[2], m_ff[1], m_ff[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stop_ff;

   // A stop word carries zero speeds
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("stop word with nonzero wheel speeds");

   // The multiplier is never left running once a command is finished
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mul_rsp.busy)
      else $error("multiplier busy while idle");

   // Restoring divide keeps its partial remainder below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < mx_ff)
      else $error("divider remainder out of range");

   // A word only appears from the emit step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_EMIT)
      else $error("result word without emit step");

endmodule

`default_nettype wire
